@@ src/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
package u8u16_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned UNIT_W = 16;
    localparam int unsigned PEND_W = 2;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;

    typedef struct packed {
        logic              emit;
        logic [UNIT_W-1:0] code_unit;
        logic              last;
        logic              truncated;
    } t_result;

    typedef struct packed {
        logic [PEND_W-1:0] pending;
        logic [UNIT_W-1:0] partial;
    } t_state;

endpackage

@@ src/u8u16_step.sv @@
// Per-byte decode logic: next sequence state and the result of one byte.
module u8u16_step (
    input  u8u16_pkg::t_state                 i_state,
    input  logic [u8u16_pkg::BYTE_W-1:0]      i_byte,
    input  logic                              i_last,
    output u8u16_pkg::t_state                 o_state,
    output u8u16_pkg::t_result                o_result
);

    logic                            have;
    logic [u8u16_pkg::UNIT_W-1:0]    unit;
    u8u16_pkg::t_state               seq;

    always_comb begin
        have = 1'b0;
        unit = '0;
        seq  = i_state;
        unique case (i_state.pending)
            u8u16_pkg::PEND_NONE: begin
                if (i_byte < u8u16_pkg::LEAD2_MIN) begin
                    unit = {8'h00, i_byte};
                    have = 1'b1;
                end else if (i_byte < u8u16_pkg::LEAD3_MIN) begin
                    seq.partial = {5'b0, i_byte[4:0], 6'b0};
                    seq.pending = u8u16_pkg::PEND_ONE;
                end else begin
                    seq.partial = {i_byte[3:0], 12'b0};
                    seq.pending = u8u16_pkg::PEND_TWO;
                end
            end
            u8u16_pkg::PEND_TWO: begin
                seq.partial = i_state.partial | {4'b0, i_byte[5:0], 6'b0};
                seq.pending = u8u16_pkg::PEND_ONE;
            end
            default: begin
                unit        = i_state.partial | {10'b0, i_byte[5:0]};
                have        = 1'b1;
                seq.pending = u8u16_pkg::PEND_NONE;
                seq.partial = '0;
            end
        endcase
    end

    always_comb begin
        if (i_last) begin
            o_state.pending       = u8u16_pkg::PEND_NONE;
            o_state.partial       = '0;
            o_result.emit         = 1'b1;
            o_result.last         = 1'b1;
            o_result.truncated    = (seq.pending != u8u16_pkg::PEND_NONE);
            o_result.code_unit    = o_result.truncated ? '0 : unit;
        end else begin
            o_state               = seq;
            o_result.emit         = have;
            o_result.last         = 1'b0;
            o_result.truncated    = 1'b0;
            o_result.code_unit    = unit;
        end
    end

endmodule

@@ src/u8u16_out_reg.sv @@
// Output result register with valid/ready hold.
module u8u16_out_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  u8u16_pkg::t_result            i_result,
    output logic                          o_free,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [u8u16_pkg::UNIT_W-1:0]  o_tdata,
    output logic                          o_tlast,
    output logic                          o_tuser
);

    logic                          r_valid;
    logic [u8u16_pkg::UNIT_W-1:0]  r_unit;
    logic                          r_last;
    logic                          r_trunc;

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_unit  <= i_result.code_unit;
            r_last  <= i_result.last;
            r_trunc <= i_result.truncated;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_unit;
    assign o_tlast  = r_last;
    assign o_tuser  = r_trunc;

endmodule

@@ src/utf8_to_utf16_stream_decoder_core.sv @@
// Top level: input byte register, sequence state, decode step and result register.
//
// Channel  | Dir | tdata               | tlast           | tuser
// s_axis   | in  | [7:0] in_byte       | in_last         | -
// m_axis   | out | [15:0] code_unit    | out_last        | [0] truncated
//
// One byte per cycle sustained while the result register is free; each byte waits in the input register
// and its result in the result register.
// Synchronous active-low reset clears valids and the pending-byte state.
// A stalled result holds its register; the input register advances when the result
// register is free or the byte gives no result.
module utf8_to_utf16_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,   // in_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] code_unit
    output logic        o_m_tlast,   // out_last
    output logic        o_m_tuser    // [0] truncated
);

    logic                          r_in_valid;
    logic [u8u16_pkg::BYTE_W-1:0]  r_in_byte;
    logic                          r_in_last;
    u8u16_pkg::t_state             r_state;
    u8u16_pkg::t_state             n_state;
    u8u16_pkg::t_result            step_res;
    logic                          out_free;
    logic                          advance;

    u8u16_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (step_res)
    );

    assign advance    = r_in_valid && (!step_res.emit || out_free);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_state.pending <= u8u16_pkg::PEND_NONE;
            r_state.partial <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    u8u16_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && step_res.emit),
        .i_result (step_res),
        .o_free   (out_free),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast),
        .o_tuser  (o_m_tuser)
    );

endmodule

@@ dv/utf8_to_utf16_stream_decoder_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench: UTF-8 byte strings in, UTF-16 code units checked against a local decoder.
module utf8_to_utf16_stream_decoder_core_test;

    typedef struct packed {
        logic [u8u16_pkg::UNIT_W-1:0] code_unit;
        logic                         last;
        logic                         truncated;
    } t_decoded;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [u8u16_pkg::BYTE_W-1:0] i_s_tdata  = '0;
    logic                         i_s_tlast  = 1'b0;
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    logic [u8u16_pkg::UNIT_W-1:0] o_m_tdata;
    logic                         o_m_tlast;
    logic                         o_m_tuser;

    logic [u8u16_pkg::PEND_W-1:0] dec_pending = u8u16_pkg::PEND_NONE;
    logic [u8u16_pkg::UNIT_W-1:0] dec_partial = '0;
    t_decoded                     pending_units[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int bytes_sent     = 0;
    int strings_sent   = 0;
    int units_checked  = 0;
    int cut_strings    = 0;

    utf8_to_utf16_stream_decoder_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic decode_byte(input logic [u8u16_pkg::BYTE_W-1:0] b,
                                         input logic fin, output t_decoded r);
        logic                         have;
        logic                         cut;
        logic [u8u16_pkg::UNIT_W-1:0] value;
        have  = 1'b0;
        value = '0;
        r     = '0;
        case (dec_pending)
            u8u16_pkg::PEND_NONE: begin
                if (b < u8u16_pkg::LEAD2_MIN) begin
                    value = {8'h00, b};
                    have  = 1'b1;
                end else if (b < u8u16_pkg::LEAD3_MIN) begin
                    dec_partial = {5'b0, b[4:0], 6'b0};
                    dec_pending = u8u16_pkg::PEND_ONE;
                end else begin
                    dec_partial = {b[3:0], 12'h000};
                    dec_pending = u8u16_pkg::PEND_TWO;
                end
            end
            u8u16_pkg::PEND_TWO: begin
                dec_partial = dec_partial | {4'b0, b[5:0], 6'b0};
                dec_pending = u8u16_pkg::PEND_ONE;
            end
            default: begin
                value       = dec_partial | {10'b0, b[5:0]};
                have        = 1'b1;
                dec_pending = u8u16_pkg::PEND_NONE;
                dec_partial = '0;
            end
        endcase
        if (fin) begin
            cut         = (dec_pending != u8u16_pkg::PEND_NONE);
            dec_pending = u8u16_pkg::PEND_NONE;
            dec_partial = '0;
            r.code_unit = cut ? '0 : value;
            r.last      = 1'b1;
            r.truncated = cut;
            return 1'b1;
        end
        r.code_unit = value;
        return have;
    endfunction

    task automatic report_mismatch(input string what, input int expv, input int gotv);
        $display("%0t mismatch %s: expected %0h, got %0h", $time, what, expv, gotv);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_decoded exp_unit;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_units.size() == 0) begin
                report_mismatch("unexpected code unit", 0, o_m_tdata);
            end else begin
                exp_unit = pending_units.pop_front();
                units_checked++;
                if (exp_unit.truncated) cut_strings++;
                if (o_m_tdata != exp_unit.code_unit)
                    report_mismatch("code_unit", exp_unit.code_unit, o_m_tdata);
                if (o_m_tlast != exp_unit.last)
                    report_mismatch("out_last", exp_unit.last, o_m_tlast);
                if (o_m_tuser != exp_unit.truncated)
                    report_mismatch("truncated", exp_unit.truncated, o_m_tuser);
            end
        end
    end

    task automatic send_byte(input logic [u8u16_pkg::BYTE_W-1:0] b, input logic fin);
        t_decoded r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_tready);
        bytes_sent++;
        if (decode_byte(b, fin, r)) pending_units = {pending_units, r};
    endtask

    task automatic send_string(input logic [u8u16_pkg::BYTE_W-1:0] seq[$]);
        for (int i = 0; i < seq.size(); i++) send_byte(seq[i], i == seq.size() - 1);
        strings_sent++;
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending_units.size() == 0);
    endtask

    function automatic logic [u8u16_pkg::BYTE_W-1:0] follow_byte();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    task automatic test_ascii();
        send_string({8'h00, 8'h7F, 8'h41});
    endtask

    task automatic test_two_byte();
        send_string({8'h80, 8'h80, 8'hDF, 8'hBF});
    endtask

    task automatic test_three_byte();
        send_string({8'hE0, 8'h80, 8'h80, 8'hFF, 8'hFF, 8'hFF});
    endtask

    task automatic test_unchecked_follow();
        send_string({8'hC3, 8'h41, 8'hE5, 8'hE0, 8'h7F});
    endtask

    task automatic test_truncated();
        send_string({8'hC3});
        send_string({8'hE2, 8'h82});
        send_string({8'hE2});
    endtask

    task automatic test_random_strings(input int n_bytes);
        logic [u8u16_pkg::BYTE_W-1:0] seq[$];
        int mode;
        int n_chars;
        int goal;
        goal = bytes_sent + n_bytes;
        while (bytes_sent < goal) begin
            seq.delete();
            mode    = $urandom_range(0, 19);
            n_chars = $urandom_range(1, 10);
            if (mode < 2) begin
                repeat (n_chars) seq = {seq, 8'($urandom_range(0, 255))};
            end else begin
                repeat (n_chars) begin
                    case ($urandom_range(0, 2))
                        0: seq = {seq, 8'($urandom_range(0, 8'h7F))};
                        1: begin
                            seq = {seq, 8'($urandom_range(8'h80, 8'hDF))};
                            seq = {seq, follow_byte()};
                        end
                        default: begin
                            seq = {seq, 8'($urandom_range(8'hE0, 8'hFF))};
                            seq = {seq, follow_byte()};
                            seq = {seq, follow_byte()};
                        end
                    endcase
                end
                if (mode < 5) begin
                    if ($urandom_range(0, 1)) begin
                        seq = {seq, 8'($urandom_range(8'h80, 8'hDF))};
                    end else begin
                        seq = {seq, 8'($urandom_range(8'hE0, 8'hFF))};
                        if ($urandom_range(0, 1)) seq = {seq, follow_byte()};
                    end
                end
            end
            send_string(seq);
            if ($urandom_range(0, 39) == 0) drain_results();
        end
    endtask

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int guard;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ascii();
        test_two_byte();
        test_three_byte();
        test_unchecked_follow();
        test_truncated();
        drain_results();

        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_strings(420);
        send_idle_pct = 82; recv_stall_pct = 0;
        test_random_strings(420);
        send_idle_pct = 0;  recv_stall_pct = 82;
        test_random_strings(420);
        send_idle_pct = 33; recv_stall_pct = 33;
        test_random_strings(420);

        i_s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        guard = 0;
        while (pending_units.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_units.size() != 0)
            report_mismatch("code units never delivered", pending_units.size(), 0);

        $display("Sent %0d bytes in %0d strings; checked %0d code units, %0d truncated strings.",
                 bytes_sent, strings_sent, units_checked, cut_strings);
        $display("Phases: free flow, sparse sender, stalling receiver, both throttled.");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
